// ===== rtl/dpke_pkg.sv =====
package dpke_pkg;

  localparam int LenW = 16;
  localparam int ExpW = 32;

  localparam logic [7:0] EcPrefix    = 8'h04;
  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagInteger  = 8'h02;
  localparam logic [7:0] ZeroByte    = 8'h00;
  localparam logic [6:0] LenCountMask = 7'h7F;
  localparam logic [6:0] MaxLenDigits = 7'd2;
  localparam int ExpBytes = 4;

  typedef enum logic [1:0] {
    KIND_STRUCT = 2'd0,
    KIND_MODULUS = 2'd1,
    KIND_POINT = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    FORM_RSA = 2'd0,
    FORM_EC = 2'd1,
    FORM_RAW = 2'd2
  } key_form_e;

  typedef enum logic [10:0] {
    PH_FIRST  = 11'b000_0000_0001,
    PH_POINT  = 11'b000_0000_0010,
    PH_SEQLEN = 11'b000_0000_0100,
    PH_SEQDIG = 11'b000_0000_1000,
    PH_TAG    = 11'b000_0001_0000,
    PH_ILEN   = 11'b000_0010_0000,
    PH_IDIG   = 11'b000_0100_0000,
    PH_IFIRST = 11'b000_1000_0000,
    PH_ICONT  = 11'b001_0000_0000,
    PH_TRAIL  = 11'b010_0000_0000,
    PH_BAD    = 11'b100_0000_0000
  } phase_e;

endpackage

// ===== rtl/der_public_key_extractor_core.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   data_byte_i, is_last_i
// out      output     out_valid_o/out_stall_i item_kind_o, byte_position_o, key_byte_o,
//                                             finished_o, parse_status_o, key_form_o,
//                                             exponent_o
// Each accepted byte gives one result item the next cycle; one byte per cycle unless stalled.
// The parser state advances in the cycle a byte is accepted; the result register holds its item.
// A stalled result blocks new input only while the result register is still occupied.
// Reset returns the parser to expecting the first byte and empties the result register.
module der_public_key_extractor_core import dpke_pkg::*; #(
  parameter int MAX_INPUT_BYTES = 511,
  parameter int MODULUS_BYTES = 256,
  parameter int POINT_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        item_kind_o,
  output logic [7:0]        byte_position_o,
  output logic [7:0]        key_byte_o,
  output logic              finished_o,
  output logic              parse_status_o,
  output logic [1:0]        key_form_o,
  output logic [ExpW-1:0]   exponent_o
);

  localparam int PW = $clog2(MAX_INPUT_BYTES + 1);
  localparam int SW = ((PW > LenW) ? PW : LenW) + 1;
  localparam int MW = $clog2(MODULUS_BYTES + 1);

  localparam logic [PW-1:0] MaxSeen = PW'(MAX_INPUT_BYTES);
  localparam logic [PW:0] PointLim = (PW + 1)'(POINT_BYTES);
  localparam logic [PW:0] PointNeedEc = (PW + 1)'(POINT_BYTES + 1);
  localparam logic [LenW-1:0] ModLimit = LenW'(MODULUS_BYTES);
  localparam logic [LenW-1:0] ExpLimit = LenW'(ExpBytes);
  localparam logic [MW-1:0] ModBytes = MW'(MODULUS_BYTES);

  phase_e            phase_q, phase_d;
  logic [PW-1:0]     seen_q, seen_d;
  logic [SW-1:0]     seq_end_q, seq_end_d;
  logic [LenW-1:0]   len_acc_q, len_acc_d;
  logic [1:0]        len_left_q, len_left_d;
  logic [LenW-1:0]   content_q, content_d;
  logic [1:0]        int_done_q, int_done_d;
  logic [MW-1:0]     mod_idx_q, mod_idx_d;
  logic [ExpW-1:0]   expo_q, expo_d;
  logic              bad_q, bad_d;
  key_form_e         form_q, form_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic [7:0]        pos_q, pos_d;
  logic [7:0]        byte_q, byte_d;
  logic              fin_q;
  logic              status_q, status_d;
  logic [1:0]        form_out_q;
  logic [ExpW-1:0]   expo_out_q, expo_out_d;

  logic              accept;
  logic              len_first;
  logic              len_err;
  logic              len_done;
  logic [LenW-1:0]   len_new;
  logic [1:0]        len_left_new;
  logic [1:0]        int_next;
  phase_e            phase_after_int;
  logic [PW-1:0]     point_idx;
  logic              strip;
  logic [LenW-1:0]   vlen;
  logic [LenW-1:0]   limit;
  logic [MW-1:0]     mod_base;
  logic              ok;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  always_comb begin
    len_first = (phase_q == PH_SEQLEN) || (phase_q == PH_ILEN);
    len_err = 1'b0;
    len_done = 1'b0;
    len_new = len_acc_q;
    len_left_new = len_left_q;
    if (len_first) begin
      if (data_byte_i[7]) begin
        len_err = ((data_byte_i[6:0] & LenCountMask) == 7'd0) ||
                  ((data_byte_i[6:0] & LenCountMask) > MaxLenDigits);
        len_new = '0;
        len_left_new = data_byte_i[1:0];
      end else begin
        len_new = LenW'(data_byte_i);
        len_done = 1'b1;
      end
    end else begin
      len_new = {len_acc_q[LenW-9:0], data_byte_i};
      len_left_new = len_left_q - 2'd1;
      len_done = (len_left_new == 2'd0);
    end
  end

  assign int_next = int_done_q + 2'd1;
  assign phase_after_int = (int_next >= 2'd2) ? PH_TRAIL : PH_TAG;
  assign point_idx = (form_q == FORM_EC) ? seen_q - PW'(1) : seen_q;
  assign strip = (data_byte_i == ZeroByte);
  assign vlen = content_q - LenW'(strip);
  assign limit = (int_done_q == 2'd0) ? ModLimit : ExpLimit;
  assign mod_base = (phase_q == PH_IFIRST) ? ModBytes - MW'(vlen) : mod_idx_q;

  always_comb begin
    phase_d = phase_q;
    seen_d = seen_q;
    seq_end_d = seq_end_q;
    len_acc_d = len_acc_q;
    len_left_d = len_left_q;
    content_d = content_q;
    int_done_d = int_done_q;
    mod_idx_d = mod_idx_q;
    expo_d = expo_q;
    bad_d = bad_q;
    form_d = form_q;
    kind_d = KIND_STRUCT;
    pos_d = '0;
    byte_d = '0;
    status_d = 1'b0;
    expo_out_d = '0;
    ok = 1'b0;

    if (seen_q >= MaxSeen) begin
      bad_d = 1'b1;
      phase_d = PH_BAD;
    end else begin
      seen_d = seen_q + PW'(1);
    end

    if (!bad_d) begin
      if ((phase_q inside {PH_TAG, PH_ILEN, PH_IDIG, PH_IFIRST, PH_ICONT, PH_TRAIL}) &&
          (SW'(seen_q) >= seq_end_q)) begin
        bad_d = 1'b1;
        phase_d = PH_BAD;
      end else begin
        case (phase_q)
          PH_FIRST: begin
            if (data_byte_i == EcPrefix) begin
              form_d = FORM_EC;
              phase_d = PH_POINT;
            end else if (data_byte_i != TagSequence) begin
              form_d = FORM_RAW;
              kind_d = KIND_POINT;
              byte_d = data_byte_i;
              phase_d = PH_POINT;
            end else begin
              form_d = FORM_RSA;
              phase_d = PH_SEQLEN;
            end
          end
          PH_POINT: begin
            if ({1'b0, point_idx} < PointLim) begin
              kind_d = KIND_POINT;
              pos_d = 8'(point_idx);
              byte_d = data_byte_i;
            end
          end
          PH_SEQLEN, PH_SEQDIG: begin
            len_acc_d = len_new;
            len_left_d = len_left_new;
            if (len_err) begin
              bad_d = 1'b1;
              phase_d = PH_BAD;
            end else if (!len_done) begin
              phase_d = PH_SEQDIG;
            end else begin
              seq_end_d = SW'(seen_q) + SW'(1) + SW'(len_new);
              phase_d = PH_TAG;
            end
          end
          PH_TAG: begin
            if (data_byte_i != TagInteger) begin
              bad_d = 1'b1;
              phase_d = PH_BAD;
            end else begin
              phase_d = PH_ILEN;
            end
          end
          PH_ILEN, PH_IDIG: begin
            len_acc_d = len_new;
            len_left_d = len_left_new;
            if (len_err) begin
              bad_d = 1'b1;
              phase_d = PH_BAD;
            end else if (!len_done) begin
              phase_d = PH_IDIG;
            end else begin
              if (int_done_q == 2'd1) begin
                expo_d = '0;
              end
              if (len_new == '0) begin
                int_done_d = int_next;
                phase_d = phase_after_int;
              end else begin
                content_d = len_new;
                phase_d = PH_IFIRST;
              end
            end
          end
          PH_IFIRST, PH_ICONT: begin
            if ((phase_q == PH_IFIRST) && (vlen > limit)) begin
              bad_d = 1'b1;
              phase_d = PH_BAD;
            end else begin
              phase_d = PH_ICONT;
              content_d = content_q - LenW'(1);
              if (content_q == LenW'(1)) begin
                int_done_d = int_next;
                phase_d = phase_after_int;
              end
              if ((phase_q == PH_IFIRST) && strip) begin
                if (int_done_q == 2'd0) begin
                  mod_idx_d = mod_base;
                end
              end else if (int_done_q == 2'd0) begin
                kind_d = KIND_MODULUS;
                pos_d = 8'(mod_base);
                byte_d = data_byte_i;
                mod_idx_d = mod_base + MW'(1);
              end else begin
                expo_d = {expo_q[ExpW-9:0], data_byte_i};
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (is_last_i) begin
      if (!bad_d) begin
        if (phase_d == PH_POINT) begin
          ok = ({1'b0, seen_d} >= ((form_d == FORM_EC) ? PointNeedEc : PointLim));
        end else if ((phase_d == PH_TAG) || (phase_d == PH_TRAIL)) begin
          ok = (SW'(seen_d) == seq_end_d) && (int_done_d >= 2'd1);
        end
      end
      status_d = !ok;
      expo_out_d = ok ? expo_d : '0;
    end
  end

  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      seen_q <= '0;
      seq_end_q <= '0;
      len_acc_q <= '0;
      len_left_q <= '0;
      content_q <= '0;
      int_done_q <= '0;
      mod_idx_q <= '0;
      expo_q <= '0;
      bad_q <= 1'b0;
      form_q <= FORM_RSA;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (is_last_i) begin
          phase_q <= PH_FIRST;
          seen_q <= '0;
          seq_end_q <= '0;
          len_acc_q <= '0;
          len_left_q <= '0;
          content_q <= '0;
          int_done_q <= '0;
          mod_idx_q <= '0;
          expo_q <= '0;
          bad_q <= 1'b0;
          form_q <= FORM_RSA;
        end else begin
          phase_q <= phase_d;
          seen_q <= seen_d;
          seq_end_q <= seq_end_d;
          len_acc_q <= len_acc_d;
          len_left_q <= len_left_d;
          content_q <= content_d;
          int_done_q <= int_done_d;
          mod_idx_q <= mod_idx_d;
          expo_q <= expo_d;
          bad_q <= bad_d;
          form_q <= form_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      pos_q <= pos_d;
      byte_q <= byte_d;
      fin_q <= is_last_i;
      status_q <= status_d;
      form_out_q <= form_d;
      expo_out_q <= expo_out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_kind_o = kind_q;
  assign byte_position_o = pos_q;
  assign key_byte_o = byte_q;
  assign finished_o = fin_q;
  assign parse_status_o = status_q;
  assign key_form_o = form_out_q;
  assign exponent_o = expo_out_q;

endmodule

// ===== rtl/dpke_checker.sv =====
module dpke_checker import dpke_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [1:0]      item_kind_o,
  input logic [7:0]      byte_position_o,
  input logic [7:0]      key_byte_o,
  input logic            finished_o,
  input logic            parse_status_o,
  input logic [1:0]      key_form_o,
  input logic [ExpW-1:0] exponent_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_byte_o) &&
      $stable(item_kind_o) && $stable(finished_o))
    else $error("Stalled result item changed.");

  a_status_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |-> !parse_status_o && (exponent_o == '0))
    else $error("Status or exponent shown on an item that is not the last.");

  a_bad_no_exponent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_status_o |-> exponent_o == '0)
    else $error("Malformed key reported an exponent.");

  a_struct_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == KIND_STRUCT) |-> (key_byte_o == '0) &&
      (byte_position_o == '0))
    else $error("Structural item carries key material.");

  a_point_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == KIND_POINT) |-> key_form_o != FORM_RSA)
    else $error("Coordinate byte emitted for an RSA key.");

endmodule

bind der_public_key_extractor_core dpke_checker u_dpke_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .item_kind_o(item_kind_o),
  .byte_position_o(byte_position_o),
  .key_byte_o(key_byte_o),
  .finished_o(finished_o),
  .parse_status_o(parse_status_o),
  .key_form_o(key_form_o),
  .exponent_o(exponent_o)
);

// ===== test/dpke_checker.sv =====
`timescale 1ns / 100ps
module dpke_tb_checker import dpke_pkg::*; #(
  parameter int MAX_INPUT_BYTES = 511,
  parameter int MODULUS_BYTES = 256,
  parameter int POINT_BYTES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [7:0]      data_byte_i,
  input  logic            is_last_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [1:0]      item_kind_i,
  input  logic [7:0]      byte_position_i,
  input  logic [7:0]      key_byte_i,
  input  logic            finished_i,
  input  logic            parse_status_i,
  input  logic [1:0]      key_form_i,
  input  logic [ExpW-1:0] exponent_i,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    item_kind_e      kind;
    logic [7:0]      position;
    logic [7:0]      key_byte;
    logic            finished;
    logic            status;
    key_form_e       form;
    logic [ExpW-1:0] exponent;
  } key_result_t;

  key_result_t expected_q[$];
  key_result_t pred;
  key_result_t want;
  int failures = 0;
  int waiting = 0;

  phase_e          phase;
  logic [8:0]      seen;
  logic [16:0]     seq_end;
  logic [LenW-1:0] len_acc;
  logic [1:0]      digits_left;
  logic [LenW-1:0] content_left;
  logic [1:0]      ints_done;
  logic [8:0]      mod_idx;
  logic [ExpW-1:0] exp_val;
  logic            bad;
  key_form_e       form;

  assign fail_count_o = failures;
  assign pending_o = waiting;

  function automatic void clear_parser();
    phase = PH_FIRST;
    seen = '0;
    seq_end = '0;
    len_acc = '0;
    digits_left = '0;
    content_left = '0;
    ints_done = '0;
    mod_idx = '0;
    exp_val = '0;
    bad = 1'b0;
    form = FORM_RSA;
  endfunction

  function automatic void set_malformed();
    bad = 1'b1;
    phase = PH_BAD;
  endfunction

  // Returns -1 for a bad encoding, 0 when length digits follow, 1 when complete.
  function automatic int length_start(logic [7:0] b);
    if (b[7]) begin
      if (b[6:0] == 7'd0 || b[6:0] > MaxLenDigits) begin
        return -1;
      end
      len_acc = '0;
      digits_left = b[1:0];
      return 0;
    end
    len_acc = LenW'(b);
    return 1;
  endfunction

  function automatic int length_more(logic [7:0] b);
    len_acc = {len_acc[7:0], b};
    digits_left = digits_left - 2'd1;
    return (digits_left == 2'd0) ? 1 : 0;
  endfunction

  function automatic void close_integer();
    ints_done = ints_done + 2'd1;
    phase = (ints_done >= 2'd2) ? PH_TRAIL : PH_TAG;
  endfunction

  function automatic void take_content(logic [7:0] b);
    if (ints_done == 2'd0) begin
      pred.kind = KIND_MODULUS;
      pred.position = mod_idx[7:0];
      pred.key_byte = b;
      mod_idx = mod_idx + 9'd1;
    end else begin
      exp_val = {exp_val[ExpW-9:0], b};
    end
    content_left = content_left - 1'b1;
    if (content_left == '0) begin
      close_integer();
    end
  endfunction

  function automatic key_result_t predict_result(logic [7:0] b, logic last);
    logic [8:0] pos;
    logic ok;
    logic strip;
    int r;
    int idx;
    int vlen;
    int limit;
    pred = '0;
    pos = seen;
    if (int'(pos) >= MAX_INPUT_BYTES) begin
      set_malformed();
    end else begin
      seen = pos + 9'd1;
    end
    if (!bad) begin
      if ((phase inside {PH_TAG, PH_ILEN, PH_IDIG, PH_IFIRST, PH_ICONT, PH_TRAIL})
          && 17'(pos) >= seq_end) begin
        set_malformed();
      end else begin
        case (phase)
          PH_FIRST: begin
            if (b == EcPrefix) begin
              form = FORM_EC;
              phase = PH_POINT;
            end else if (b != TagSequence) begin
              form = FORM_RAW;
              pred.kind = KIND_POINT;
              pred.key_byte = b;
              phase = PH_POINT;
            end else begin
              form = FORM_RSA;
              phase = PH_SEQLEN;
            end
          end
          PH_POINT: begin
            idx = int'(pos) - ((form == FORM_EC) ? 1 : 0);
            if (idx < POINT_BYTES) begin
              pred.kind = KIND_POINT;
              pred.position = 8'(idx);
              pred.key_byte = b;
            end
          end
          PH_SEQLEN, PH_SEQDIG: begin
            r = (phase == PH_SEQLEN) ? length_start(b) : length_more(b);
            if (r < 0) begin
              set_malformed();
            end else if (r == 0) begin
              phase = PH_SEQDIG;
            end else begin
              seq_end = 17'(pos) + 17'd1 + 17'(len_acc);
              phase = PH_TAG;
            end
          end
          PH_TAG: begin
            if (b != TagInteger) begin
              set_malformed();
            end else begin
              phase = PH_ILEN;
            end
          end
          PH_ILEN, PH_IDIG: begin
            r = (phase == PH_ILEN) ? length_start(b) : length_more(b);
            if (r < 0) begin
              set_malformed();
            end else if (r == 0) begin
              phase = PH_IDIG;
            end else begin
              if (ints_done == 2'd1) begin
                exp_val = '0;
              end
              if (len_acc == '0) begin
                close_integer();
              end else begin
                content_left = len_acc;
                phase = PH_IFIRST;
              end
            end
          end
          PH_IFIRST: begin
            strip = (b == ZeroByte);
            vlen = int'(content_left) - (strip ? 1 : 0);
            limit = (ints_done == 2'd0) ? MODULUS_BYTES : ExpBytes;
            if (vlen > limit) begin
              set_malformed();
            end else begin
              if (ints_done == 2'd0) begin
                mod_idx = 9'(MODULUS_BYTES - vlen);
              end
              phase = PH_ICONT;
              if (strip) begin
                content_left = content_left - 1'b1;
                if (content_left == '0) begin
                  close_integer();
                end
              end else begin
                take_content(b);
              end
            end
          end
          PH_ICONT: begin
            take_content(b);
          end
          default: begin
          end
        endcase
      end
    end
    pred.form = form;
    pred.finished = last;
    if (last) begin
      ok = !bad;
      if (ok) begin
        if (phase == PH_POINT) begin
          ok = int'(seen) >= POINT_BYTES + ((form == FORM_EC) ? 1 : 0);
        end else if (phase == PH_TAG || phase == PH_TRAIL) begin
          ok = (17'(seen) == seq_end) && (ints_done >= 2'd1);
        end else begin
          ok = 1'b0;
        end
      end
      pred.status = !ok;
      pred.exponent = ok ? exp_val : '0;
      clear_parser();
    end
    return pred;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result item expected none, actual kind %0d byte 0x%0h", $time,
                   item_kind_i, key_byte_i);
          failures++;
        end else begin
          want = expected_q.pop_front();
          check_field("item_kind", want.kind, item_kind_i);
          check_field("byte_position", want.position, byte_position_i);
          check_field("key_byte", want.key_byte, key_byte_i);
          check_field("finished", want.finished, finished_i);
          check_field("parse_status", want.status, parse_status_i);
          check_field("key_form", want.form, key_form_i);
          check_field("exponent", want.exponent, exponent_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_result(data_byte_i, is_last_i));
      end
    end
    waiting = expected_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import dpke_pkg::*;

  typedef enum {MSG_RSA, MSG_POINT, MSG_NOISE} msg_kind_e;
  typedef enum {FLAW_NONE, FLAW_SEQ_LEN, FLAW_TRUNCATE, FLAW_CORRUPT, FLAW_OVERRUN,
                FLAW_BAD_LEN} flaw_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      data_byte_i;
  logic            is_last_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [1:0]      item_kind_o;
  logic [7:0]      byte_position_o;
  logic [7:0]      key_byte_o;
  logic            finished_o;
  logic            parse_status_o;
  logic [1:0]      key_form_o;
  logic [ExpW-1:0] exponent_o;
  int              failures;
  int              pending;

  logic [7:0] msg[$];
  logic [7:0] body[$];
  logic [7:0] len_bytes[$];
  bit         sender_quiet;

  always #5 clk_i = ~clk_i;

  der_public_key_extractor_core dut (.*);

  dpke_tb_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .is_last_i      (is_last_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_i    (item_kind_o),
    .byte_position_i(byte_position_o),
    .key_byte_i     (key_byte_o),
    .finished_i     (finished_o),
    .parse_status_i (parse_status_o),
    .key_form_i     (key_form_o),
    .exponent_i     (exponent_o),
    .fail_count_o   (failures),
    .pending_o      (pending)
  );

  task automatic send_message();
    int gap;
    foreach (msg[i]) begin
      gap = sender_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i = 1'b1;
      data_byte_i = msg[i];
      is_last_i = (i == msg.size() - 1);
      do @(posedge clk_i); while (in_stall_o);
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic push_random(input int n);
    repeat (n) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic encode_length(input int n);
    int digits;
    len_bytes = {};
    digits = (n > 255) ? 2 : (n > 127) ? $urandom_range(1, 2) : $urandom_range(0, 2);
    if (digits == 0) begin
      len_bytes.push_back(8'(n));
    end else begin
      len_bytes.push_back({1'b1, 7'(digits)});
      if (digits == 2) begin
        len_bytes.push_back(8'(n >> 8));
      end
      len_bytes.push_back(8'(n));
    end
  endtask

  task automatic add_integer(input int len, input bit lead_zero);
    encode_length(len + int'(lead_zero));
    body.push_back(TagInteger);
    body = {body, len_bytes};
    if (lead_zero) begin
      body.push_back(ZeroByte);
    end
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic make_rsa_message();
    int ints;
    int mod_len;
    int seq_len;
    flaw_e flaw;
    ints = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : 2;
    mod_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 24);
    body = {};
    if (ints > 0) begin
      add_integer(mod_len, $urandom_range(0, 1));
    end
    if (ints > 1) begin
      add_integer($urandom_range(0, 5), $urandom_range(0, 1));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
    end
    flaw = ($urandom_range(0, 9) < 5) ? flaw_e'($urandom_range(1, 5)) : FLAW_NONE;
    seq_len = body.size();
    if (flaw == FLAW_SEQ_LEN) begin
      seq_len = ($urandom_range(0, 1) || seq_len == 0) ? seq_len + 1 : seq_len - 1;
    end
    encode_length(seq_len);
    msg = {TagSequence, len_bytes, body};
    case (flaw)
      FLAW_TRUNCATE: repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
      FLAW_CORRUPT: msg[$urandom_range(1, msg.size() - 1)] = 8'($urandom_range(0, 255));
      FLAW_OVERRUN: push_random($urandom_range(1, 3));
      FLAW_BAD_LEN: msg[1] = ($urandom_range(0, 1) == 0) ? 8'h80 : 8'($urandom_range(8'h83, 8'hFF));
      default: begin
      end
    endcase
  endtask

  task automatic make_point_message();
    int n;
    logic [7:0] lead;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : 64 + $urandom_range(0, 3);
    msg = {};
    if ($urandom_range(0, 1) == 0) begin
      msg.push_back(EcPrefix);
    end else begin
      do lead = 8'($urandom_range(0, 255)); while (lead == EcPrefix || lead == TagSequence);
      msg.push_back(lead);
      n--;
    end
    push_random(n);
  endtask

  initial begin
    int hold;
    bit sink_quiet;
    sink_quiet = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        sink_quiet = !sink_quiet;
      end
      hold = sink_quiet ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int random_items;
    msg_kind_e kind;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    is_last_i = 1'b0;
    sender_quiet = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    msg = {TagSequence, 8'h03, TagInteger, 8'h01, 8'h80};
    send_message();
    msg = {TagSequence, 8'h09, TagInteger, 8'h01, ZeroByte,
           TagInteger, 8'h03, 8'h01, ZeroByte, 8'h01, 8'hFF};
    send_message();
    msg = {TagSequence, ZeroByte};
    send_message();
    msg = {TagSequence, 8'h83};
    send_message();
    msg = {TagSequence, 8'h02, 8'h05, 8'h7F};
    send_message();
    msg = {EcPrefix, 8'hFF};
    send_message();
    msg = {TagSequence, 8'h01, TagInteger, 8'h01, 8'h05};
    send_message();
    msg = {TagSequence, 8'h04, TagInteger, 8'h01};
    send_message();
    wait_drained();

    msg = {TagSequence, 8'h82, 8'h01, 8'h0C, TagInteger, 8'h82, 8'h01, 8'h01, ZeroByte};
    push_random(256);
    msg = {msg, TagInteger, 8'h05, ZeroByte, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg = {TagSequence, 8'h82, 8'h01, 8'h10, TagInteger, 8'h82, 8'h01, 8'h01,
           8'h9A, 8'h11, 8'h22};
    send_message();
    msg = {TagSequence, 8'h0A, TagInteger, 8'h01, 8'h01,
           TagInteger, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_message();
    msg = {EcPrefix};
    push_random(66);
    send_message();
    msg = {8'hFF};
    push_random(63);
    send_message();
    msg = {8'h00};
    push_random(62);
    send_message();
    sender_quiet = 1'b1;
    msg = {EcPrefix};
    push_random(512);
    send_message();
    wait_drained();

    random_items = 0;
    while (random_items < 400) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      hold_kind: begin
        int pick;
        pick = $urandom_range(0, 99);
        kind = (pick < 65) ? MSG_RSA : (pick < 80) ? MSG_POINT : MSG_NOISE;
      end
      case (kind)
        MSG_RSA: make_rsa_message();
        MSG_POINT: make_point_message();
        default: begin
          msg = {};
          case ($urandom_range(0, 2))
            0: msg.push_back(TagSequence);
            1: msg.push_back(EcPrefix);
            default: push_random(1);
          endcase
          push_random($urandom_range(0, 10));
        end
      endcase
      send_message();
      random_items += msg.size();
      if ($urandom_range(0, 11) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dpke_pkg.sv
rtl/der_public_key_extractor_core.sv
rtl/dpke_checker.sv
test/dpke_checker.sv
test/tb.sv
